// ===== sv/plbp_pkg.sv =====
// plbp_pkg: shared types, codes and pattern tables for the status LED pattern generator
// no dependencies; imported by priority_led_blink_pattern
`default_nettype none

package plbp_pkg;

   // operation codes carried by each request beat
   typedef enum logic [1:0] {
      OP_SET_FLAG  = 2'd0,
      OP_CLEAR_ALL = 2'd1,
      OP_TICK      = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   localparam int CondWidth  = 3;
   localparam int PhaseWidth = 2;
   localparam int DurWidth   = 13;
   localparam int TimeWidth  = 32;
   localparam int NumConds   = 7;

   typedef logic [CondWidth-1:0]  cond_type;
   typedef logic [PhaseWidth-1:0] phase_type;
   typedef logic [DurWidth-1:0]   dur_type;
   typedef logic [TimeWidth-1:0]  time_type;

   // pattern and condition codes share one numbering
   localparam cond_type COND_FATAL        = 3'd0;
   localparam cond_type COND_OTA_VERIFY   = 3'd1;
   localparam cond_type COND_OTA_DOWNLOAD = 3'd2;
   localparam cond_type COND_PROVISION    = 3'd3;
   localparam cond_type COND_WIFI         = 3'd4;
   localparam cond_type COND_CLOUD        = 3'd5;
   localparam cond_type COND_BOOT         = 3'd6;
   localparam cond_type PATTERN_NONE      = 3'd7;

   // phase length in ms for each pattern and phase; unused phases are zero, all 200 for PATTERN_NONE
   function automatic dur_type phase_ms(input cond_type pat, input phase_type ph);
      dur_type d;
      d = 13'd0;
      unique case (pat)
         COND_FATAL:        d = (ph == 2'd0) ? 13'd3000 : ((ph == 2'd1) ? 13'd1000 : 13'd0);
         COND_OTA_VERIFY:   d = (ph == 2'd0 || ph == 2'd1) ? 13'd100 : 13'd0;
         COND_OTA_DOWNLOAD: d = (ph == 2'd0) ? 13'd80 : ((ph == 2'd1) ? 13'd420 : 13'd0);
         COND_PROVISION:    d = (ph == 2'd0 || ph == 2'd1) ? 13'd1000 : 13'd0;
         COND_WIFI:         d = (ph == 2'd3) ? 13'd1700 : 13'd100;
         COND_CLOUD:        d = (ph == 2'd0) ? 13'd50 : ((ph == 2'd1) ? 13'd4950 : 13'd0);
         COND_BOOT:         d = (ph == 2'd0 || ph == 2'd1) ? 13'd200 : 13'd0;
         default:           d = 13'd200;
      endcase
      return d;
   endfunction

   // whether the LED is lit in a given phase of a pattern
   function automatic logic phase_lit(input cond_type pat, input phase_type ph);
      logic lit;
      if (pat == COND_WIFI) begin
         lit = (ph == 2'd0) || (ph == 2'd2);
      end else if (pat != PATTERN_NONE) begin
         lit = (ph == 2'd0);
      end else begin
         lit = 1'b0;
      end
      return lit;
   endfunction

endpackage

`default_nettype wire

// ===== sv/priority_led_blink_pattern.sv =====
// priority_led_blink_pattern: top level of the status LED pattern generator
// depends on plbp_pkg for operation codes and the pattern tables
`default_nettype none

// Takes one request beat per cycle while responses drain, and returns exactly one
// response beat for each in the following cycle: the flag update or tick is worked out
// in a single pass of logic (priority encode, table lookup, one 32-bit wrapping compare)
// and lands in the response register. A new request is taken whenever the response
// register is empty or being drained in the same cycle, so the block sustains one beat
// per clock. Set and clear-all beats change only the flags; the LED, pattern and phase
// move on ticks. pin_level reflects active_low as written before the request was taken.
module priority_led_blink_pattern
   import plbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_active_low_we,
   input  wire logic        csr_active_low,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [2:0]  req_condition,
   input  wire logic        req_enable,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_led_on,
   output logic             rsp_pin_level,
   output logic [2:0]       rsp_pattern,
   output logic [1:0]       rsp_phase
);

   logic                active_low_ff;
   logic [NumConds-1:0] flags_ff, flags_in;
   cond_type            pattern_ff, pattern_in;
   phase_type           phase_ff, phase_in;
   time_type            start_ff, start_in;
   logic                led_ff, led_in;

   logic                rsp_valid_ff;
   logic                rsp_led_ff, rsp_pin_ff;
   cond_type            rsp_pattern_ff;
   phase_type           rsp_phase_ff;

   logic                accept;
   cond_type            target;
   time_type            elapsed;
   phase_type           phase_next;

   // handshake: take a beat when the response slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // highest priority active condition, boot self-test by default
   always_comb begin
      target = COND_BOOT;
      for (int c = NumConds - 1; c >= 0; c--) begin
         if (flags_ff[c]) begin
            target = CondWidth'(c);
         end
      end
   end

   // elapsed time in the current phase and the following phase index
   assign elapsed    = req_now_ms - start_ff;
   assign phase_next = (pattern_ff == COND_WIFI) ? phase_type'(phase_ff + 2'd1)
                                                 : phase_type'({1'b0, ~phase_ff[0]});

   // next state for one request beat
   always_comb begin
      flags_in   = flags_ff;
      pattern_in = pattern_ff;
      phase_in   = phase_ff;
      start_in   = start_ff;
      led_in     = led_ff;
      unique case (op_type'(req_operation))
         OP_SET_FLAG: begin
            if (req_condition != PATTERN_NONE) begin
               flags_in[req_condition] = req_enable;
            end
         end
         OP_CLEAR_ALL: begin
            flags_in = '0;
         end
         OP_TICK: begin
            if (target != pattern_ff) begin
               pattern_in = target;
               phase_in   = 2'd0;
               start_in   = req_now_ms;
               led_in     = phase_lit(target, 2'd0);
            end else if (elapsed >= {19'd0, phase_ms(pattern_ff, phase_ff)}) begin
               phase_in = phase_next;
               start_in = req_now_ms;
               led_in   = phase_lit(pattern_ff, phase_next);
            end
         end
         OP_UNUSED: begin
            flags_in = flags_ff;
         end
         default: begin
            flags_in = flags_ff;
         end
      endcase
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= 1'b0;
      end else if (csr_active_low_we) begin
         active_low_ff <= csr_active_low;
      end
   end

   // pattern state, updated on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         pattern_ff <= PATTERN_NONE;
         phase_ff   <= 2'd0;
         start_ff   <= '0;
         led_ff     <= 1'b0;
      end else if (accept) begin
         flags_ff   <= flags_in;
         pattern_ff <= pattern_in;
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         led_ff     <= led_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_led_ff     <= led_in;
         rsp_pin_ff     <= led_in ^ active_low_ff;
         rsp_pattern_ff <= pattern_in;
         rsp_phase_ff   <= phase_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_pattern   = rsp_pattern_ff;
   assign rsp_phase     = rsp_phase_ff;

endmodule

`default_nettype wire
